// ----- design/ptb_pkg.sv -----
// Package for the palindromic tree builder: sizes, operation codes and
// small helpers. It depends on nothing else.
package ptb_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int ALPHABET   = 26;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int TOTAL_W    = NODE_W + 1;
  localparam int LEN_W      = NODE_W + 1;
  localparam int SYM_W      = 5;
  localparam int EDGE_DEPTH = MAX_NODES * ALPHABET;
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int CLR_CNT_W  = $clog2(2 * ALPHABET);
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PROP   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  function automatic logic [NODE_W-1:0] sat_add(input logic [NODE_W-1:0] a,
                                                 input logic [NODE_W-1:0] b);
    logic [NODE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[NODE_W] ? '1 : s[NODE_W-1:0];
  endfunction

  function automatic logic [EDGE_AW-1:0] edge_addr(input logic [NODE_W-1:0] nd,
                                                   input logic [SYM_W-1:0] c);
    return EDGE_AW'(32'(nd) * ALPHABET + 32'(c));
  endfunction

endpackage

// ----- design/ptb_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/palindromic_tree_builder.sv -----
// Top level of the palindromic tree builder: sequencer, counters and stores.
// It depends on ptb_pkg and ptb_ram.
//
// Usage: one command beat enters on the s_axis channel; tuser carries the
// operation (clear, append, propagate, read), tdata the symbol and node index.
// Exactly one result beat leaves on the m_axis channel for each command, with
// the error flag in tuser. The block takes one command at a time: s_axis_tready
// is high only while it is idle, and stays low until the result beat is taken.
// A read looks up the node's stores and registers the result. An append follows
// suffix links one step at a time in its walks, and when a new node is made its
// edge row is zeroed one entry a cycle through the single write port of the edge
// memory. Propagate works one node at a time, with a read-modify-write of the
// occurrence memory for each node.
// After reset the block builds the two roots before it raises s_axis_tready.
// A stalled receiver holds the result beat in place and the block simply
// waits.
module palindromic_tree_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // symbol, node_index
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // node, pal_length, pal_count, occurrences,
                                     // fail_node, new_node, node_total
  output logic        m_axis_tuser   // error
);
  import ptb_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_W0   = 5'd2;
  localparam logic [4:0] S_W1   = 5'd3;
  localparam logic [4:0] S_W2   = 5'd4;
  localparam logic [4:0] S_E0   = 5'd5;
  localparam logic [4:0] S_E1   = 5'd6;
  localparam logic [4:0] S_OCC0 = 5'd7;
  localparam logic [4:0] S_OCC1 = 5'd8;
  localparam logic [4:0] S_ROW  = 5'd9;
  localparam logic [4:0] S_SPC0 = 5'd10;
  localparam logic [4:0] S_SPC1 = 5'd11;
  localparam logic [4:0] S_P0   = 5'd12;
  localparam logic [4:0] S_P1   = 5'd13;
  localparam logic [4:0] S_P2   = 5'd14;
  localparam logic [4:0] S_RD   = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]           state_q;
  logic                 boot_q;
  logic [NODE_W-1:0]    last_q;
  logic [NODE_W-1:0]    stot_q;
  logic [TOTAL_W-1:0]   ncnt_q;

  logic [SYM_W-1:0]     sym_q;
  logic [NODE_W-1:0]    np_q, x_q, xlink_q, cur_q, cur_link_q, now_q;
  logic [NODE_W-1:0]    child_q, link_new_q, i_q, f_q, occi_q, rep_q;
  logic signed [LEN_W-1:0] xlen_q, cur_len_q;
  logic [CLR_CNT_W-1:0] k_q;
  logic                 walk2_q, new_q, err_q;

  logic [NODE_W-1:0]    o_node_q, o_cnt_q, o_occ_q, o_fail_q;
  logic [LEN_W-1:0]     o_len_q;
  logic                 o_new_q, o_err_q;
  logic [TOTAL_W-1:0]   o_total_q;

  logic                 len_we, lnk_we, occ_we, spc_we, sym_we, edge_we;
  logic [NODE_W-1:0]    len_wa, lnk_wa, occ_wa, spc_wa, sym_wa;
  logic [NODE_W-1:0]    len_ra, lnk_ra, occ_ra, spc_ra, sym_ra;
  logic [EDGE_AW-1:0]   edge_wa, edge_ra;
  logic [LEN_W-1:0]     len_wd, len_rd;
  logic [NODE_W-1:0]    lnk_wd, lnk_rd, occ_wd, occ_rd, spc_wd, spc_rd;
  logic [NODE_W-1:0]    edge_wd, edge_rd;
  logic [SYM_W-1:0]     sym_rd;
  logic signed [NODE_W+1:0] pos;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_DONE);
  assign m_axis_tuser  = o_err_q;
  assign m_axis_tdata  = {1'b0, o_total_q, o_new_q, o_fail_q, o_occ_q, o_cnt_q,
                          o_len_q, o_node_q};

  assign pos = $signed({2'b00, np_q}) - $signed({len_rd[LEN_W-1], len_rd})
               - (NODE_W+2)'(1);

  always_comb begin
    len_we = 1'b0; len_wa = '0; len_wd = '0;
    lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0;
    occ_we = 1'b0; occ_wa = '0; occ_wd = '0;
    spc_we = 1'b0; spc_wa = '0; spc_wd = '0;
    sym_we = 1'b0; sym_wa = np_q;
    edge_we = 1'b0; edge_wa = '0; edge_wd = '0;
    len_ra = rep_q; lnk_ra = rep_q; occ_ra = rep_q; spc_ra = rep_q;
    sym_ra = pos[NODE_W-1:0];
    edge_ra = edge_addr(x_q, sym_q);
    case (state_q)
      S_CLR: begin
        edge_we = 1'b1;
        edge_wa = EDGE_AW'(k_q);
        if (k_q < CLR_CNT_W'(2)) begin
          len_we = 1'b1; lnk_we = 1'b1; occ_we = 1'b1; spc_we = 1'b1;
          len_wa = NODE_W'(k_q); lnk_wa = NODE_W'(k_q);
          occ_wa = NODE_W'(k_q); spc_wa = NODE_W'(k_q);
          len_wd = k_q[0] ? '1 : '0;
          lnk_wd = k_q[0] ? '0 : NODE_W'(1);
        end
      end
      S_W0: begin
        len_ra = x_q;
        lnk_ra = x_q;
      end
      S_E1: begin
        sym_we = ~walk2_q && !(edge_rd == '0 && ncnt_q >= TOTAL_W'(MAX_NODES));
      end
      S_OCC0: occ_ra = child_q;
      S_OCC1: begin
        occ_we = 1'b1;
        occ_wa = child_q;
        occ_wd = sat_add(occ_rd, NODE_W'(1));
      end
      S_ROW: begin
        edge_we = 1'b1;
        edge_wa = edge_addr(now_q, SYM_W'(k_q));
        if (k_q == '0) begin
          len_we = 1'b1; len_wa = now_q; len_wd = cur_len_q + LEN_W'(2);
          occ_we = 1'b1; occ_wa = now_q; occ_wd = NODE_W'(1);
        end
      end
      S_SPC0: spc_ra = link_new_q;
      S_SPC1: begin
        spc_we = 1'b1; spc_wa = now_q; spc_wd = sat_add(spc_rd, NODE_W'(1));
        lnk_we = 1'b1; lnk_wa = now_q; lnk_wd = link_new_q;
        edge_we = 1'b1; edge_wa = edge_addr(cur_q, sym_q); edge_wd = now_q;
      end
      S_P0: begin
        lnk_ra = i_q;
        occ_ra = i_q;
      end
      S_P1: occ_ra = lnk_rd;
      S_P2: begin
        occ_we = 1'b1; occ_wa = f_q; occ_wd = sat_add(occ_rd, occi_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      boot_q  <= 1'b1;
      k_q     <= '0;
      last_q  <= '0;
      stot_q  <= '0;
      ncnt_q  <= TOTAL_W'(2);
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sym_q <= s_axis_tdata[SYM_W-1:0];
            new_q <= 1'b0;
            err_q <= 1'b0;
            rep_q <= last_q;
            case (s_axis_tuser)
              OP_CLEAR: begin
                k_q     <= '0;
                state_q <= S_CLR;
              end
              OP_APPEND: begin
                if (s_axis_tdata[SYM_W-1:0] >= SYM_W'(ALPHABET) ||
                    stot_q >= NODE_W'(MAX_NODES - 1)) begin
                  err_q   <= 1'b1;
                  state_q <= S_RD;
                end else begin
                  np_q    <= stot_q + NODE_W'(1);
                  x_q     <= last_q;
                  walk2_q <= 1'b0;
                  state_q <= S_W0;
                end
              end
              OP_PROP: begin
                i_q     <= NODE_W'(ncnt_q - TOTAL_W'(1));
                state_q <= S_P0;
              end
              default: begin
                rep_q   <= s_axis_tdata[SYM_W +: NODE_W];
                err_q   <= {1'b0, s_axis_tdata[SYM_W +: NODE_W]} >= ncnt_q;
                state_q <= S_RD;
              end
            endcase
          end
        end
        S_CLR: begin
          k_q <= k_q + CLR_CNT_W'(1);
          if (k_q == CLR_CNT_W'(2 * ALPHABET - 1)) begin
            ncnt_q  <= TOTAL_W'(2);
            last_q  <= '0;
            stot_q  <= '0;
            rep_q   <= '0;
            boot_q  <= 1'b0;
            state_q <= boot_q ? S_IDLE : S_RD;
          end
        end
        S_W0: state_q <= S_W1;
        S_W1: begin
          xlink_q <= lnk_rd;
          xlen_q  <= len_rd;
          if (len_rd[LEN_W-1]) begin
            if (!walk2_q) begin
              cur_q <= x_q; cur_len_q <= len_rd; cur_link_q <= lnk_rd;
            end
            state_q <= S_E0;
          end else if (pos > 0) begin
            state_q <= S_W2;
          end else begin
            x_q     <= lnk_rd;
            state_q <= S_W0;
          end
        end
        S_W2: begin
          if (sym_rd == sym_q) begin
            if (!walk2_q) begin
              cur_q <= x_q; cur_len_q <= xlen_q; cur_link_q <= xlink_q;
            end
            state_q <= S_E0;
          end else begin
            x_q     <= xlink_q;
            state_q <= S_W0;
          end
        end
        S_E0: state_q <= S_E1;
        S_E1: begin
          if (walk2_q) begin
            link_new_q <= edge_rd;
            state_q    <= S_SPC0;
          end else if (edge_rd == '0 && ncnt_q >= TOTAL_W'(MAX_NODES)) begin
            err_q   <= 1'b1;
            state_q <= S_RD;
          end else begin
            stot_q <= np_q;
            if (edge_rd != '0) begin
              child_q <= edge_rd;
              state_q <= S_OCC0;
            end else begin
              now_q   <= NODE_W'(ncnt_q);
              ncnt_q  <= ncnt_q + TOTAL_W'(1);
              k_q     <= '0;
              state_q <= S_ROW;
            end
          end
        end
        S_OCC0: state_q <= S_OCC1;
        S_OCC1: begin
          last_q  <= child_q;
          rep_q   <= child_q;
          state_q <= S_RD;
        end
        S_ROW: begin
          k_q <= k_q + CLR_CNT_W'(1);
          if (k_q == CLR_CNT_W'(ALPHABET - 1)) begin
            x_q     <= cur_link_q;
            walk2_q <= 1'b1;
            state_q <= S_W0;
          end
        end
        S_SPC0: state_q <= S_SPC1;
        S_SPC1: begin
          last_q  <= now_q;
          rep_q   <= now_q;
          new_q   <= 1'b1;
          state_q <= S_RD;
        end
        S_P0: state_q <= S_P1;
        S_P1: begin
          f_q     <= lnk_rd;
          occi_q  <= occ_rd;
          state_q <= S_P2;
        end
        S_P2: begin
          if (i_q == NODE_W'(1)) begin
            state_q <= S_RD;
          end else begin
            i_q     <= i_q - NODE_W'(1);
            state_q <= S_P0;
          end
        end
        S_RD: state_q <= S_OUT;
        S_OUT: state_q <= S_DONE;
        S_DONE: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      o_err_q   <= err_q;
      o_total_q <= ncnt_q;
      o_node_q  <= err_q ? '0 : rep_q;
      o_len_q   <= err_q ? '0 : len_rd;
      o_cnt_q   <= err_q ? '0 : spc_rd;
      o_occ_q   <= err_q ? '0 : occ_rd;
      o_fail_q  <= err_q ? '0 : lnk_rd;
      o_new_q   <= err_q ? 1'b0 : new_q;
    end
  end

  ptb_ram #(.WIDTH(LEN_W), .DEPTH(MAX_NODES)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_wa), .wdata_i(len_wd),
    .raddr_i(len_ra), .rdata_o(len_rd)
  );

  ptb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_link (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_wa), .wdata_i(lnk_wd),
    .raddr_i(lnk_ra), .rdata_o(lnk_rd)
  );

  ptb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_occ (
    .clk_i, .we_i(occ_we), .waddr_i(occ_wa), .wdata_i(occ_wd),
    .raddr_i(occ_ra), .rdata_o(occ_rd)
  );

  ptb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_spc (
    .clk_i, .we_i(spc_we), .waddr_i(spc_wa), .wdata_i(spc_wd),
    .raddr_i(spc_ra), .rdata_o(spc_rd)
  );

  ptb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_NODES)) u_sym (
    .clk_i, .we_i(sym_we), .waddr_i(sym_wa), .wdata_i(sym_q),
    .raddr_i(sym_ra), .rdata_o(sym_rd)
  );

  ptb_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_DEPTH)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_wa), .wdata_i(edge_wd),
    .raddr_i(edge_ra), .rdata_o(edge_rd)
  );

endmodule
